// ===== hw/rtl/s20sc_pkg.sv =====
package s20sc_pkg;

  // Default number of double rounds.
  localparam int DOUBLE_ROUNDS_DEF = 10;

  // Quarter-round steps in one half round, and round cells in one double round.
  localparam int STEPS_PER_HALF = 4;
  localparam int CELLS_PER_DOUBLE = 8;

  // Stream payload widths.
  localparam int WORD_W  = 64;
  localparam int NWORDS  = 8;
  localparam int CNT_W   = 7;
  localparam int TDATA_W = 520;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE  = 3'd5;

  // Largest block size in bytes.
  localparam logic [CNT_W-1:0] MAX_BYTES = 7'd64;

  // Constant words for 32-byte and 16-byte keys.
  localparam logic [31:0] SIGMA [4] = '{32'h61707865, 32'h3320646e,
                                        32'h79622d32, 32'h6b206574};
  localparam logic [31:0] TAU   [4] = '{32'h61707865, 32'h3120646e,
                                        32'h79622d36, 32'h6b206574};

  // Rotation amount of each quarter-round step.
  localparam logic [4:0] ROT_AMT [4] = '{5'd7, 5'd9, 5'd13, 5'd18};

  // State word of role a, b, c, d for each quarter round; column half first.
  localparam logic [3:0] QR_IDX [2][4][4] = '{
    '{'{4'd0,  4'd4,  4'd8,  4'd12},
      '{4'd5,  4'd9,  4'd13, 4'd1},
      '{4'd10, 4'd14, 4'd2,  4'd6},
      '{4'd15, 4'd3,  4'd7,  4'd11}},
    '{'{4'd0,  4'd1,  4'd2,  4'd3},
      '{4'd5,  4'd6,  4'd7,  4'd4},
      '{4'd10, 4'd11, 4'd8,  4'd9},
      '{4'd15, 4'd12, 4'd13, 4'd14}}
  };

  // Key, nonce and mode registers.
  typedef struct packed {
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [63:0] key_c;
    logic [63:0] key_d;
    logic [63:0] nonce;
    logic        wide;
  } s20sc_cfg_t;

  // One block as it travels down the chain of round cells.
  typedef struct packed {
    logic [15:0][31:0]        x;
    logic [NWORDS-1:0][63:0]  data;
    logic [CNT_W-1:0]         cnt;
    logic [63:0]              ctr;
  } s20sc_item_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
    logic [5:0] m;
    begin
      m = 6'd32 - {1'b0, n};
      rotl = (v << n) | (v >> m);
    end
  endfunction

  // Build the initial 16-word state from configuration and block counter.
  function automatic logic [15:0][31:0] init_state(input s20sc_cfg_t cfg,
                                                   input logic [63:0] ctr);
    logic [15:0][31:0] s;
    logic [63:0] k2;
    logic [63:0] k3;
    begin
      k2 = cfg.wide ? cfg.key_c : cfg.key_a;
      k3 = cfg.wide ? cfg.key_d : cfg.key_b;
      s[0]  = cfg.wide ? SIGMA[0] : TAU[0];
      s[1]  = cfg.key_a[31:0];
      s[2]  = cfg.key_a[63:32];
      s[3]  = cfg.key_b[31:0];
      s[4]  = cfg.key_b[63:32];
      s[5]  = cfg.wide ? SIGMA[1] : TAU[1];
      s[6]  = cfg.nonce[31:0];
      s[7]  = cfg.nonce[63:32];
      s[8]  = ctr[31:0];
      s[9]  = ctr[63:32];
      s[10] = cfg.wide ? SIGMA[2] : TAU[2];
      s[11] = k2[31:0];
      s[12] = k2[63:32];
      s[13] = k3[31:0];
      s[14] = k3[63:32];
      s[15] = cfg.wide ? SIGMA[3] : TAU[3];
      init_state = s;
    end
  endfunction

endpackage

// ===== hw/rtl/s20sc_cell.sv =====
module s20sc_cell
  import s20sc_pkg::*;
#(
  parameter int STEP = 0,
  parameter int ROW  = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  s20sc_item_t up_item,
  output logic        dn_valid,
  input  logic        dn_ready,
  output s20sc_item_t dn_item
);

  // Roles of this step: target word and the two words that are added.
  localparam int TGT = (STEP + 1) % STEPS_PER_HALF;
  localparam int OPA = STEP;
  localparam int OPB = (STEP + 3) % STEPS_PER_HALF;

  logic        valid_r;
  s20sc_item_t item_r;
  s20sc_item_t item_nxt;

  // One add-rotate-xor on each of the four quarter rounds in parallel.
  always_comb begin
    item_nxt = up_item;
    for (int q = 0; q < 4; q++) begin
      item_nxt.x[QR_IDX[ROW][q][TGT]] = up_item.x[QR_IDX[ROW][q][TGT]] ^
        rotl(up_item.x[QR_IDX[ROW][q][OPA]] + up_item.x[QR_IDX[ROW][q][OPB]],
             ROT_AMT[STEP]);
    end
  end

  // The slot takes a new transaction when it is empty or being drained.
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

// ===== hw/rtl/s20sc_final.sv =====
module s20sc_final
  import s20sc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  s20sc_cfg_t         cfg,
  input  logic               up_valid,
  output logic               up_ready,
  input  s20sc_item_t        up_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TDATA_W-1:0] out_data
);

  logic [15:0][31:0]       init_w;
  logic [15:0][31:0]       ks;
  logic [NWORDS-1:0][63:0] word_nxt;
  logic [NWORDS-1:0][63:0] word_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    valid_r;

  // Add the initial state back and XOR the keystream into the valid bytes; bytes past the count are zero.
  always_comb begin
    init_w = init_state(cfg, up_item.ctr);
    for (int i = 0; i < 16; i++) begin
      ks[i] = up_item.x[i] + init_w[i];
    end
    for (int w = 0; w < NWORDS; w++) begin
      word_nxt[w] = up_item.data[w] ^ {ks[2*w+1], ks[2*w]};
      for (int b = 0; b < 8; b++) begin
        if (up_item.cnt <= CNT_W'(8 * w + b)) begin
          word_nxt[w][8*b +: 8] = 8'h00;
        end
      end
    end
  end

  // Output register; it refills while the receiver drains it.
  assign up_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      word_r <= word_nxt;
      cnt_r  <= up_item.cnt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = {1'b0, cnt_r, word_r};

endmodule

// ===== hw/rtl/salsa20_stream_cipher.sv =====
// Salsa20 stream cipher, one message block of up to 64 bytes per transaction.
// Input channel in_*: in_tdata carries the eight 64-bit message words and the
// byte count; a count above 64 is taken as 64. Output channel out_*: the
// eight result words (message XOR keystream, bytes past the count zero) and
// the count that was used. Configuration port cfg_*: key words, nonce and
// key mode, written while the block is idle; every write to a listed register
// clears the 64-bit block counter, which otherwise advances once per block
// with a nonzero count and wraps at 2^64.
// The datapath has one round cell per add-rotate-xor step of the double
// rounds, then the add-back and output register. A new block is taken every
// cycle while the receiver does not stall; the rate is set by the chain of
// round cells, one pipeline slot per step.
// When the receiver stalls, the output register holds its result and empty
// slots down the chain fill up, so the input keeps taking blocks until the
// whole chain is full.
// Reset (synchronous, active low) empties the chain, clears the key, nonce
// and counter, and selects the 32-byte key mode.
module salsa20_stream_cipher
  import s20sc_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Fields from bit 0 up: data_word_0 .. data_word_7, byte_count, pad bit.
  input  logic [TDATA_W-1:0]    in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0 up: out_word_0 .. out_word_7, out_byte_count, pad bit.
  output logic [TDATA_W-1:0]    out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NCELL = CELLS_PER_DOUBLE * DOUBLE_ROUNDS;

  s20sc_cfg_t       cfg_r;
  logic [63:0]      ctr_r;
  logic [CNT_W-1:0] in_cnt;
  logic             in_fire;
  logic             cfg_hit;

  logic        cell_valid [NCELL+1];
  logic        cell_ready [NCELL+1];
  s20sc_item_t cell_item  [NCELL+1];

  // Saturate the byte count at one full block.
  assign in_cnt  = in_tdata[518] ? MAX_BYTES : in_tdata[518:512];
  assign in_fire = in_tvalid && in_tready;
  assign cfg_hit = cfg_we && (cfg_index <= REG_WIDE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_a <= '0;
      cfg_r.key_b <= '0;
      cfg_r.key_c <= '0;
      cfg_r.key_d <= '0;
      cfg_r.nonce <= '0;
      cfg_r.wide  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_A: cfg_r.key_a <= cfg_wdata;
        REG_KEY_B: cfg_r.key_b <= cfg_wdata;
        REG_KEY_C: cfg_r.key_c <= cfg_wdata;
        REG_KEY_D: cfg_r.key_d <= cfg_wdata;
        REG_NONCE: cfg_r.nonce <= cfg_wdata;
        REG_WIDE:  cfg_r.wide  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Block counter: cleared by a register write, advanced per nonempty block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
    end else if (cfg_hit) begin
      ctr_r <= '0;
    end else if (in_fire && (in_cnt != '0)) begin
      ctr_r <= ctr_r + 64'd1;
    end
  end

  // Head of the chain: initial state, message and counter of this block.
  always_comb begin
    cell_item[0].x    = init_state(cfg_r, ctr_r);
    cell_item[0].data = in_tdata[511:0];
    cell_item[0].cnt  = in_cnt;
    cell_item[0].ctr  = ctr_r;
  end

  assign cell_valid[0] = in_tvalid;
  assign in_tready     = cell_ready[0];

  // Chain of round cells, four steps per half round.
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    s20sc_cell #(
      .STEP(g % STEPS_PER_HALF),
      .ROW ((g / STEPS_PER_HALF) % 2)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_valid(cell_valid[g]),
      .up_ready(cell_ready[g]),
      .up_item (cell_item[g]),
      .dn_valid(cell_valid[g+1]),
      .dn_ready(cell_ready[g+1]),
      .dn_item (cell_item[g+1])
    );
  end

  // Add-back, keystream XOR and output register.
  s20sc_final u_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (cell_valid[NCELL]),
    .up_ready (cell_ready[NCELL]),
    .up_item  (cell_item[NCELL]),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata)
  );

  // A nonempty block with no register write advances the counter by one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_cnt != '0) && !cfg_hit) |=> (ctr_r == $past(ctr_r) + 64'd1))
    else $error("block counter did not advance");

  // A write to a listed register clears the counter.
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (ctr_r == '0))
    else $error("block counter not cleared by register write");

  // The reported count never exceeds one block and the pad bit stays zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[518:512] <= MAX_BYTES) && !out_tdata[519]))
    else $error("output count out of range");

  // A block with a zero count gives all-zero result words.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[518:512] == '0)) |-> (out_tdata[511:0] == '0))
    else $error("zero-count block has nonzero data");

endmodule
